>>> src/sha_pkg.sv
// SHA-512/384 shared package: datapath command struct, write-source codes,
// round constants, initial hash values and the sigma functions.
// No dependencies.
package sha_pkg;

    localparam int unsigned WORD_W      = 64;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned ROUNDS      = 80;
    localparam int unsigned LEN_W       = 32;
    localparam logic [3:0]  FULL_BYTES  = 4'd8;
    localparam logic [2:0]  LAST_K_512  = 3'd7;
    localparam logic [2:0]  LAST_K_384  = 3'd5;

    // source of a word written into the block buffer
    typedef enum logic [2:0] {
        WR_DATA,
        WR_LAST,
        WR_MARK,
        WR_ZERO,
        WR_LEN
    } t_wr_sel;

    // controller to datapath commands
    typedef struct packed {
        logic             latch;
        logic             wr_en;
        t_wr_sel          wr_sel;
        logic [3:0]       wr_idx;
        logic [LEN_W-1:0] len;
        logic             start;
        logic             round;
        logic [6:0]       rnd;
        logic             add;
        logic             init;
        logic             init_mode;
        logic [2:0]       out_idx;
    } t_dp_cmd;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] big_sig0(input logic [63:0] x);
        big_sig0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
    endfunction

    function automatic logic [63:0] big_sig1(input logic [63:0] x);
        big_sig1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
    endfunction

    function automatic logic [63:0] sml_sig0(input logic [63:0] x);
        sml_sig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic logic [63:0] sml_sig1(input logic [63:0] x);
        sml_sig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction

    // initial hash: mode 0 SHA-512, mode 1 SHA-384
    function automatic logic [63:0] init_hash(input logic mode, input logic [2:0] i);
        logic [63:0] v;
        v = '0;
        if (!mode) begin
            case (i)
                3'd0: v = 64'h6a09e667f3bcc908;
                3'd1: v = 64'hbb67ae8584caa73b;
                3'd2: v = 64'h3c6ef372fe94f82b;
                3'd3: v = 64'ha54ff53a5f1d36f1;
                3'd4: v = 64'h510e527fade682d1;
                3'd5: v = 64'h9b05688c2b3e6c1f;
                3'd6: v = 64'h1f83d9abfb41bd6b;
                default: v = 64'h5be0cd19137e2179;
            endcase
        end else begin
            case (i)
                3'd0: v = 64'hcbbb9d5dc1059ed8;
                3'd1: v = 64'h629a292a367cd507;
                3'd2: v = 64'h9159015a3070dd17;
                3'd3: v = 64'h152fecd8f70e5939;
                3'd4: v = 64'h67332667ffc00b31;
                3'd5: v = 64'h8eb44a8768581511;
                3'd6: v = 64'hdb0c2e0d64f98fa7;
                default: v = 64'h47b5481dbefa4fa4;
            endcase
        end
        init_hash = v;
    endfunction

    // round constants
    function automatic logic [63:0] round_k(input logic [6:0] t);
        logic [63:0] k;
        case (t)
            7'd0:  k = 64'h428a2f98d728ae22;  7'd1:  k = 64'h7137449123ef65cd;
            7'd2:  k = 64'hb5c0fbcfec4d3b2f;  7'd3:  k = 64'he9b5dba58189dbbc;
            7'd4:  k = 64'h3956c25bf348b538;  7'd5:  k = 64'h59f111f1b605d019;
            7'd6:  k = 64'h923f82a4af194f9b;  7'd7:  k = 64'hab1c5ed5da6d8118;
            7'd8:  k = 64'hd807aa98a3030242;  7'd9:  k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec;  7'd79: k = 64'h6c44198c4a475817;
            default: k = '0;
        endcase
        round_k = k;
    endfunction

endpackage

>>> src/sha_if.sv
// Valid/ready channel interfaces for message words and digest words.
// Depends on nothing.
interface sha_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        last;
    modport source (output valid, data_word, valid_bytes, last, input ready);
    modport sink   (input valid, data_word, valid_bytes, last, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

>>> src/sha_dp.sv
// SHA-512/384 datapath: block buffer as a 16-word schedule shift line,
// working variables, chaining value. Depends on sha_pkg.
module sha_dp (
    input  logic               i_clk,
    input  sha_pkg::t_dp_cmd   i_cmd,
    input  logic [63:0]        i_data_word,
    input  logic [3:0]         i_valid_bytes,
    output logic [63:0]        o_digest_word
);

    logic [63:0] r_data;
    logic [3:0]  r_nb;
    logic [63:0] r_w [16];
    logic [63:0] r_v [8];
    logic [63:0] r_h [8];

    logic [63:0] n_wr_word;
    logic [63:0] last_word;
    logic [63:0] t1;
    logic [63:0] t2;
    logic [63:0] w_new;

    // masked last word with the marker byte right after the valid bytes when fewer than 8 are valid
    always_comb begin
        last_word = '0;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < r_nb) begin
                last_word[63-8*b -: 8] = r_data[63-8*b -: 8];
            end else if (4'(b) == r_nb) begin
                last_word[63-8*b -: 8] = 8'h80;
            end
        end
    end

    // buffer write source
    always_comb begin
        case (i_cmd.wr_sel)
            sha_pkg::WR_DATA: n_wr_word = r_data;
            sha_pkg::WR_LAST: n_wr_word = last_word;
            sha_pkg::WR_MARK: n_wr_word = 64'h8000_0000_0000_0000;
            sha_pkg::WR_LEN:  n_wr_word = {{(64-sha_pkg::LEN_W){1'b0}}, i_cmd.len};
            default:          n_wr_word = '0;
        endcase
    end

    // round and schedule logic
    always_comb begin
        t1 = r_v[7] + sha_pkg::big_sig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
           + sha_pkg::round_k(i_cmd.rnd) + r_w[0];
        t2 = sha_pkg::big_sig0(r_v[0])
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        w_new = sha_pkg::sml_sig1(r_w[14]) + r_w[9] + sha_pkg::sml_sig0(r_w[1]) + r_w[0];
    end

    // input latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_data <= i_data_word;
            r_nb   <= (i_valid_bytes > sha_pkg::FULL_BYTES) ? sha_pkg::FULL_BYTES
                                                            : i_valid_bytes;
        end
    end

    // block buffer / schedule
    always_ff @(posedge i_clk) begin
        if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_new;
        end else if (i_cmd.wr_en) begin
            r_w[i_cmd.wr_idx] <= n_wr_word;
        end
    end

    // working variables
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
        end else if (i_cmd.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    // chaining value
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= sha_pkg::init_hash(i_cmd.init_mode, 3'(i));
            end
        end else if (i_cmd.add) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= r_h[i] + r_v[i];
            end
        end
    end

    assign o_digest_word = r_h[i_cmd.out_idx];

endmodule

>>> src/sha_ctrl.sv
// SHA-512/384 controller: word intake, padding sequence, round count,
// digest output. Depends on sha_pkg.
module sha_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_in_valid,
    input  logic [3:0]        i_in_valid_bytes,
    input  logic              i_in_last,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [2:0]        o_word_index,
    output logic              o_last_word,
    output sha_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_WRITE, S_MARK, S_PADCHK, S_FILL1, S_FILL2,
        S_START, S_ROUND, S_ADD, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        R_IDLE, R_MARK, R_FILL2, R_OUT
    } t_ret;

    t_state r_state, n_state;
    t_ret   r_ret, n_ret;
    logic [4:0]  r_idx, n_idx;
    logic [31:0] r_len, n_len;
    logic        r_mode, n_mode;
    logic [6:0]  r_rnd, n_rnd;
    logic [2:0]  r_k, n_k;
    logic        r_last, n_last;
    logic [3:0]  r_nb, n_nb;
    logic [2:0]  last_k;

    assign last_k       = r_mode ? sha_pkg::LAST_K_384 : sha_pkg::LAST_K_512;
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = (r_state == S_OUT);
    assign o_word_index = r_k;
    assign o_last_word  = (r_k == last_k);

    // next state and datapath commands
    always_comb begin
        n_state = r_state; n_ret = r_ret; n_idx = r_idx; n_len = r_len;
        n_mode = r_mode; n_rnd = r_rnd; n_k = r_k; n_last = r_last; n_nb = r_nb;
        o_cmd           = '0;
        o_cmd.wr_sel    = sha_pkg::WR_ZERO;
        o_cmd.wr_idx    = r_idx[3:0];
        o_cmd.len       = r_len;
        o_cmd.rnd       = r_rnd;
        o_cmd.out_idx   = r_k;
        o_cmd.init_mode = r_mode;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_last = i_in_last;
                    n_nb = (i_in_valid_bytes > sha_pkg::FULL_BYTES) ? sha_pkg::FULL_BYTES
                                                                    : i_in_valid_bytes;
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.wr_en = 1'b1;
                if (!r_last) begin
                    o_cmd.wr_sel = sha_pkg::WR_DATA;
                    n_len = r_len + 32'd64;
                    if (r_idx == 5'd15) begin
                        n_idx = '0; n_ret = R_IDLE; n_state = S_START;
                    end else begin
                        n_idx = r_idx + 5'd1; n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.wr_sel = sha_pkg::WR_LAST;
                    n_len = r_len + {25'd0, r_nb, 3'd0};
                    if (r_nb != sha_pkg::FULL_BYTES) begin
                        n_idx = r_idx + 5'd1; n_state = S_PADCHK;
                    end else if (r_idx == 5'd15) begin
                        n_idx = '0; n_ret = R_MARK; n_state = S_START;
                    end else begin
                        n_idx = r_idx + 5'd1; n_state = S_MARK;
                    end
                end
            end
            S_MARK: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.wr_sel = sha_pkg::WR_MARK;
                n_idx = r_idx + 5'd1;
                n_state = S_PADCHK;
            end
            S_PADCHK: begin
                // length needs the last two words; spill to an extra block if taken
                n_state = (r_idx >= 5'd15) ? S_FILL1 : S_FILL2;
            end
            S_FILL1: begin
                if (r_idx == 5'd16) begin
                    n_idx = '0; n_ret = R_FILL2; n_state = S_START;
                end else begin
                    o_cmd.wr_en = 1'b1;
                    n_idx = r_idx + 5'd1;
                end
            end
            S_FILL2: begin
                o_cmd.wr_en = 1'b1;
                if (r_idx == 5'd15) begin
                    o_cmd.wr_sel = sha_pkg::WR_LEN;
                    n_idx = '0; n_ret = R_OUT; n_state = S_START;
                end else begin
                    n_idx = r_idx + 5'd1;
                end
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_rnd = '0;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                if (r_rnd == 7'(sha_pkg::ROUNDS - 1)) begin
                    n_state = S_ADD;
                end else begin
                    n_rnd = r_rnd + 7'd1;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                case (r_ret)
                    R_IDLE:  n_state = S_IDLE;
                    R_MARK:  n_state = S_MARK;
                    R_FILL2: n_state = S_FILL2;
                    default: begin
                        n_k = '0; n_state = S_OUT;
                    end
                endcase
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (r_k == last_k) begin
                        o_cmd.init = 1'b1;
                        n_idx = '0; n_len = '0; n_state = S_IDLE;
                    end else begin
                        n_k = r_k + 3'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        // mode write restarts the message
        if (i_cfg_we) begin
            n_mode = i_cfg_wdata;
            o_cmd.init = 1'b1;
            o_cmd.init_mode = i_cfg_wdata;
            n_idx = '0;
            n_len = '0;
        end
        // reset loads the SHA-512 initial hash
        if (!i_rst_n) begin
            o_cmd.init      = 1'b1;
            o_cmd.init_mode = 1'b0;
        end
    end

    // state and registered control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ret <= R_IDLE; r_idx <= '0; r_len <= '0;
            r_mode <= 1'b0; r_rnd <= '0; r_k <= '0; r_last <= 1'b0; r_nb <= '0;
        end else begin
            r_state <= n_state; r_ret <= n_ret; r_idx <= n_idx; r_len <= n_len;
            r_mode <= n_mode; r_rnd <= n_rnd; r_k <= n_k; r_last <= n_last; r_nb <= n_nb;
        end
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("input and output active together");
    a_rnd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_rnd < 7'(sha_pkg::ROUNDS)))
        else $error("round counter out of range");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= 5'd16) else $error("buffer index out of range");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last_word) |=> (r_state == S_IDLE && r_len == '0))
        else $error("no restart after final digest word");
`endif

endmodule

>>> src/sha512_sha384_hash_unit.sv
// SHA-512/384 hash unit: each word is stored before the next is taken; every
// 16th word adds a compression (80 rounds at one round per cycle in a single
// round unit, plus load and add). The last word adds padding writes and one or
// two compressions, then 8 (SHA-512) or 6 (SHA-384) digest words are offered
// one per cycle while the receiver is ready. A mode write restarts the message
// with that mode's initial hash. Depends on sha_pkg, sha_if, sha_ctrl, sha_dp.
module sha512_sha384_hash_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    sha_in_if.sink        i_in,
    sha_out_if.source     o_out
);

    sha_pkg::t_dp_cmd cmd;

    sha_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in.valid),
        .i_in_valid_bytes (i_in.valid_bytes),
        .i_in_last        (i_in.last),
        .o_in_ready       (i_in.ready),
        .o_out_valid      (o_out.valid),
        .i_out_ready      (o_out.ready),
        .o_word_index     (o_out.word_index),
        .o_last_word      (o_out.last_word),
        .o_cmd            (cmd)
    );

    sha_dp u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_data_word   (i_in.data_word),
        .i_valid_bytes (i_in.valid_bytes),
        .o_digest_word (o_out.digest_word)
    );

endmodule

>>> dv/tb_top.sv
// Testbench for the SHA-512/384 hash unit: directed table of messages, then random
// messages, checked word by word against a behavioral hash predictor.
// Depends on sha_pkg, sha_if and sha512_sha384_hash_unit.
`timescale 1ns / 100ps

module tb_top;

    localparam int HALF_PERIOD = 1;

    typedef struct packed {
        logic [63:0] digest;
        logic [2:0]  index;
        logic        tail;
    } t_digest_word;

    // one directed word; exp_first is nonzero only when it can be read off directly
    typedef struct {
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic        last;
        logic [63:0] exp_first;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_wdata = 1'b0;

    sha_in_if  in_ch ();
    sha_out_if out_ch ();

    sha512_sha384_hash_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // predictor state
    logic        mode_384;
    logic [63:0] chain [8];
    logic [63:0] blk [16];
    int unsigned word_pos;
    logic [31:0] msg_bits;

    t_digest_word digest_q[$];
    logic [63:0]  first_word_q[$];
    int  mismatches = 0;
    int  digests_seen = 0;
    int  words_sent = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  long_hold = 1'b0;

    function automatic logic [63:0] ror(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    task automatic run_block();
        logic [63:0] w [80];
        logic [63:0] v [8];
        logic [63:0] t1, t2;
        for (int j = 0; j < 16; j++) w[j] = blk[j];
        for (int j = 16; j < 80; j++)
            w[j] = (ror(w[j-2], 19) ^ ror(w[j-2], 61) ^ (w[j-2] >> 6)) + w[j-7]
                 + (ror(w[j-15], 1) ^ ror(w[j-15], 8) ^ (w[j-15] >> 7)) + w[j-16];
        for (int j = 0; j < 8; j++) v[j] = chain[j];
        for (int j = 0; j < 80; j++) begin
            t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::round_k(j[6:0]) + w[j];
            t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++) chain[j] += v[j];
    endtask

    task automatic restart_msg();
        for (int j = 0; j < 8; j++) chain[j] = sha_pkg::init_hash(mode_384, j[2:0]);
        word_pos = 0;
        msg_bits = '0;
    endtask

    // expected digest words for one accepted message word
    task automatic predict_word(input logic [63:0] data, input logic [3:0] nb_in,
                                input logic fin);
        int unsigned nb;
        int unsigned cnt;
        logic [63:0] word;
        if (!fin) begin
            blk[word_pos] = data;
            msg_bits += 32'd64;
            word_pos++;
            if (word_pos == 16) begin
                run_block();
                word_pos = 0;
            end
            return;
        end
        nb = (nb_in > 8) ? 8 : nb_in;
        msg_bits += nb * 8;
        word = (nb == 0) ? 64'd0 : (data & ({64{1'b1}} << (64 - 8 * nb)));
        if (nb < 8) begin
            blk[word_pos] = word | (64'h80 << (56 - 8 * nb));
        end else begin
            blk[word_pos] = word;
            word_pos++;
            if (word_pos == 16) begin
                run_block();
                word_pos = 0;
            end
            blk[word_pos] = 64'h80 << 56;
        end
        word_pos++;
        if (word_pos > 14) begin
            while (word_pos < 16) blk[word_pos++] = '0;
            run_block();
            word_pos = 0;
        end
        while (word_pos < 15) blk[word_pos++] = '0;
        blk[15] = {32'd0, msg_bits};
        run_block();
        cnt = mode_384 ? 6 : 8;
        for (int k = 0; k < cnt; k++)
            digest_q.push_back('{chain[k], k[2:0], (k + 1 == cnt)});
        restart_msg();
    endtask

    // drive one word and wait for acceptance; valid drops only on idle cycles
    task automatic send_word(input logic [63:0] data, input logic [3:0] nb,
                             input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.data_word   <= data;
        in_ch.valid_bytes <= nb;
        in_ch.last        <= fin;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_word(data, nb, fin);
        words_sent++;
        @(negedge i_clk);
    endtask

    // random message: mostly up to 20 words, now and then up to 40 over a block boundary
    task automatic send_message();
        int n;
        logic [3:0] nb;
        n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(20);
        for (int i = 0; i < n; i++)
            send_word({$urandom, $urandom}, 4'($urandom_range(15)), 1'b0);
        nb = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
        send_word({$urandom, $urandom}, nb, 1'b1);
    endtask

    // stop offering words, then wait for all digest words
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (digest_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        mode_384 = m;
        restart_msg();
    endtask

    // receiver: ready stalls, plus one long hold-off
    always @(negedge i_clk) begin
        if (long_hold) out_ch.ready <= 1'b0;
        else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // digest checker
    always @(posedge i_clk) begin
        t_digest_word got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.digest_word, out_ch.word_index, out_ch.last_word};
            digests_seen++;
            if (digest_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected digest word %h idx %0d", $time,
                         got.digest, got.index);
            end else begin
                want = digest_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    $display("%0t: digest mismatch exp %h/%0d/%0b got %h/%0d/%0b", $time,
                             want.digest, want.index, want.tail,
                             got.digest, got.index, got.tail);
                end
                if (want.index == 0 && first_word_q.size() != 0) begin
                    if (first_word_q[0] != '0 && first_word_q[0] !== got.digest) begin
                        mismatches++;
                        $display("%0t: known digest exp %h got %h", $time,
                                 first_word_q[0], got.digest);
                    end
                    void'(first_word_q.pop_front());
                end
            end
        end
    end

    // hold-off process: counts its own cycles
    task automatic hold_receiver(input int cycles);
        long_hold = 1'b1;
        repeat (cycles) @(negedge i_clk);
        long_hold = 1'b0;
    endtask

    t_dir_row dir_rows[$];

    initial begin
        in_ch.valid       = 1'b0;
        in_ch.data_word   = '0;
        in_ch.valid_bytes = '0;
        in_ch.last        = 1'b0;
        out_ch.ready      = 1'b1;
        mode_384 = 1'b0;
        for (int j = 0; j < 16; j++) blk[j] = '0;
        restart_msg();

        // empty message and "abc" (standard vectors), byte-count extremes,
        // oversized count, short non-last word, ignored low bytes
        dir_rows.push_back('{64'h0, 4'd0, 1'b1, 64'hcf83e1357eefb8bd});
        dir_rows.push_back('{64'h6162630000000000, 4'd3, 1'b1, 64'hddaf35a193617aba});
        dir_rows.push_back('{64'h616263ffffffffff, 4'd3, 1'b1, 64'hddaf35a193617aba});
        dir_rows.push_back('{64'hffffffffffffffff, 4'd8, 1'b1, 64'h0});
        dir_rows.push_back('{64'hffffffffffffffff, 4'd15, 1'b1, 64'h0});
        dir_rows.push_back('{64'h0123456789abcdef, 4'd1, 1'b0, 64'h0});
        dir_rows.push_back('{64'hfedcba9876543210, 4'd7, 1'b1, 64'h0});
        dir_rows.push_back('{64'h0, 4'd9, 1'b1, 64'h0});

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].last) first_word_q.push_back(dir_rows[r].exp_first);
            send_word(dir_rows[r].data, dir_rows[r].nbytes, dir_rows[r].last);
        end
        // block-boundary lengths: 13, 14, 15, 16 full words before the last
        for (int n = 13; n <= 16; n++) begin
            for (int i = 0; i < n; i++) send_word({$urandom, $urandom}, 4'd8, 1'b0);
            send_word({$urandom, $urandom}, 4'($urandom_range(8)), 1'b1);
        end

        // SHA-384 empty message, then back
        write_mode(1'b1);
        first_word_q.push_back(64'h38b060a751ac9638);
        send_word(64'h0, 4'd0, 1'b1);
        // mode write aborts a partial message
        send_word({$urandom, $urandom}, 4'd8, 1'b0);
        write_mode(1'b0);

        // random phases over idling patterns
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 31 : 87) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 31 : 87) : 0;
            if (ph == 0) fork hold_receiver(600); join_none
            while (words_sent < 30 * (ph + 1) + 70) send_message();
            write_mode($urandom_range(1));
        end
        write_mode(1'b1);
        send_idle_pct = 0; recv_stall_pct = 0;
        repeat (5) send_message();
        write_mode(1'b0);
        drain();

        $display("covered %0d message words, %0d digest words, both modes, all idle mixes",
                 words_sent, digests_seen);
        if (mismatches == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout with %0d digest words pending", digest_q.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
